// ----- design/rv32_pkg.sv -----
// Package: shared types and constants for the RV32I subset execute block
`timescale 1ns / 1ps
package rv32_pkg;

  localparam logic [6:0] OP_R      = 7'd51;
  localparam logic [6:0] OP_I      = 7'd19;
  localparam logic [6:0] OP_LOAD   = 7'd3;
  localparam logic [6:0] OP_STORE  = 7'd35;
  localparam logic [6:0] OP_BRANCH = 7'd99;
  localparam logic [6:0] OP_LUI    = 7'd55;
  localparam logic [6:0] OP_JAL    = 7'd111;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef enum logic [3:0] {
    K_ADD, K_XOR, K_ORI, K_SRAI, K_LB, K_LW, K_SB, K_SW,
    K_BEQ, K_LUI, K_JAL, K_BAD
  } kind_t;

  // Back-end sequencing: memory clear, normal issue, load data return
  typedef enum logic [1:0] {S_CLEAR, S_RUN, S_LOAD} bstate_t;

  // Decoded instruction passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } dec_t;

endpackage

// ----- design/rv32_ram.sv -----
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module rv32_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- design/rv32_front.sv -----
// Front end: accept instruction beats, decode them and queue the result
`timescale 1ns / 1ps
module rv32_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_instruction,
  output logic                 q_valid,
  output rv32_pkg::dec_t       q_data,
  input  logic                 q_take
);
  import rv32_pkg::*;

  dec_t       dec;
  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  dec_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign opc = in_instruction[6:0];
  assign f3  = in_instruction[14:12];
  assign f7  = in_instruction[31:25];

  // Classify the instruction and form its immediate
  always_comb begin
    dec.rd  = in_instruction[11:7];
    dec.rs1 = in_instruction[19:15];
    dec.rs2 = in_instruction[24:20];
    dec.imm = {{20{in_instruction[31]}}, in_instruction[31:20]};
    dec.kind = K_BAD;
    case (opc)
      OP_R: begin
        if (f3 == 3'd0 && f7 == 7'd0) dec.kind = K_ADD;
        else if (f3 == 3'd4 && f7 == 7'd0) dec.kind = K_XOR;
      end
      OP_I: begin
        if (f3 == 3'd6) dec.kind = K_ORI;
        else if (f3 == 3'd5 && f7 == 7'h20) dec.kind = K_SRAI;
      end
      OP_LOAD: begin
        if (f3 == 3'd0) dec.kind = K_LB;
        else if (f3 == 3'd2) dec.kind = K_LW;
      end
      OP_STORE: begin
        dec.imm = {{20{in_instruction[31]}}, in_instruction[31:25], in_instruction[11:7]};
        if (f3 == 3'd0) dec.kind = K_SB;
        else if (f3 == 3'd2) dec.kind = K_SW;
      end
      OP_BRANCH: begin
        dec.imm = {{19{in_instruction[31]}}, in_instruction[31], in_instruction[7],
                   in_instruction[30:25], in_instruction[11:8], 1'b0};
        if (f3 == 3'd0) dec.kind = K_BEQ;
      end
      OP_LUI: begin
        dec.imm  = {in_instruction[31:12], 12'd0};
        dec.kind = K_LUI;
      end
      OP_JAL: begin
        dec.imm = {{11{in_instruction[31]}}, in_instruction[31], in_instruction[19:12],
                   in_instruction[20], in_instruction[30:21], 1'b0};
        dec.kind = K_JAL;
      end
      default: dec.kind = K_BAD;
    endcase
  end

  // Two-entry queue between decode and execute
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_take;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= dec;
    end
  end
endmodule

// ----- design/rv32_back.sv -----
// Back end: register file, data memory, PC and result register
`timescale 1ns / 1ps
module rv32_back #(
  parameter int DATA_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  rv32_pkg::dec_t        q_data,
  output logic                  q_take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_next_pc,
  output logic                  out_reg_written,
  output logic [4:0]            out_dest_reg,
  output logic signed [31:0]    out_write_value,
  output logic [1:0]            out_status
);
  import rv32_pkg::*;

  localparam int WORDS = (DATA_BYTES + 3) / 4;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(DATA_BYTES) + 1;
  localparam logic [CW-1:0] CLR_END = CW'(DATA_BYTES);

  bstate_t st_r, st_nxt;

  logic [31:0] rf_r [32];
  logic [31:0] pc_r;
  logic [CW-1:0] clr_r;
  dec_t        cur;
  logic [31:0] a, b, addr, sum_pc4, val;
  logic        wr, in_rng, is_mem;
  logic [1:0]  status;
  logic [31:0] npc;
  logic [32:0] end_addr;
  logic        outbuf_free;
  logic        fire;

  // Pending load held across the memory read cycle
  dec_t        ld_r;
  logic [1:0]  lane_r;
  logic [31:0] ld_npc_r;

  // Byte lanes: four RAMs, byte i at lane i%4 row i/4
  logic [3:0]    we;
  logic [WW-1:0] row [4];
  logic [7:0]    wd  [4];
  logic [7:0]    rd  [4];
  logic [31:0]   word_addr;

  assign cur     = q_data;
  assign a       = (cur.rs1 == 5'd0) ? 32'd0 : rf_r[cur.rs1];
  assign b       = (cur.rs2 == 5'd0) ? 32'd0 : rf_r[cur.rs2];
  assign sum_pc4 = pc_r + 32'd4;
  assign addr    = a + cur.imm;
  assign is_mem  = cur.kind == K_LB || cur.kind == K_LW || cur.kind == K_SB ||
                   cur.kind == K_SW;
  assign end_addr = {1'b0, addr} +
                    ((cur.kind == K_LW || cur.kind == K_SW) ? 33'd4 : 33'd1);
  assign in_rng  = end_addr <= 33'(DATA_BYTES);

  assign outbuf_free = !out_valid || !out_stall;
  assign fire   = (st_r == S_RUN) && q_valid && outbuf_free;
  assign q_take = fire;

  // Execute the non-load part
  always_comb begin
    npc    = sum_pc4;
    val    = 32'd0;
    wr     = 1'b0;
    status = ST_OK;
    case (cur.kind)
      K_ADD:  begin val = a + b; wr = 1'b1; end
      K_XOR:  begin val = a ^ b; wr = 1'b1; end
      K_ORI:  begin val = a | cur.imm; wr = 1'b1; end
      K_SRAI: begin val = 32'($signed(a) >>> cur.rs2); wr = 1'b1; end
      K_LUI:  begin val = cur.imm; wr = 1'b1; end
      K_JAL:  begin val = sum_pc4; wr = 1'b1; npc = pc_r + cur.imm; end
      K_BEQ:  begin if (a == b) npc = pc_r + cur.imm; end
      K_LB, K_LW, K_SB, K_SW: begin if (!in_rng) status = ST_RANGE; end
      K_BAD:  begin status = ST_UNKNOWN; npc = pc_r; end
      default: begin status = ST_UNKNOWN; npc = pc_r; end
    endcase
  end

  // Drive byte-lane addresses and store data
  assign word_addr = addr >> 2;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [1:0]  k;
      logic [31:0] r;
      k = 2'(i) - addr[1:0];
      r = word_addr + ((2'(i) < addr[1:0]) ? 32'd1 : 32'd0);
      row[i] = WW'(r);
      wd[i]  = b[8*k +: 8];
      we[i]  = 1'b0;
      if (st_r == S_CLEAR) begin
        row[i] = WW'(clr_r >> 2);
        wd[i]  = 8'd0;
        we[i]  = 1'b1;
      end else if (fire && in_rng) begin
        if (cur.kind == K_SW) we[i] = 1'b1;
        else if (cur.kind == K_SB) we[i] = (k == 2'd0);
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    rv32_ram #(.WIDTH(8), .DEPTH(1 << WW)) u_ram (
      .clk(clk), .we(we[g]), .addr(row[g]), .wdata(wd[g]), .rdata(rd[g])
    );
  end

  // Next state: clear memory after reset, pass through S_LOAD for in-range loads
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLEAR: if (clr_r + CW'(4) >= CLR_END) st_nxt = S_RUN;
      S_RUN:   if (fire && in_rng && (cur.kind == K_LB || cur.kind == K_LW)) st_nxt = S_LOAD;
      S_LOAD:  st_nxt = S_RUN;
      default: st_nxt = S_CLEAR;
    endcase
  end

  // Assemble load data from byte lanes
  logic [31:0] ld_word;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_word[8*i +: 8] = rd[2'(i) + lane_r];
    end
    if (ld_r.kind == K_LB) ld_word = {{24{ld_word[7]}}, ld_word[7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLEAR;
      clr_r     <= '0;
      pc_r      <= 32'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < 32; i++) rf_r[i] <= 32'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLEAR) clr_r <= clr_r + CW'(4);
      // Raise valid on a new result beat, drop it once the beat is taken
      if ((fire && !(is_mem && in_rng && (cur.kind == K_LB || cur.kind == K_LW))) ||
          st_r == S_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        pc_r <= npc;
        ld_r <= cur;
        lane_r <= addr[1:0];
        ld_npc_r <= npc;
        if (!(is_mem && in_rng && (cur.kind == K_LB || cur.kind == K_LW))) begin
          out_next_pc     <= npc;
          out_status      <= status;
          out_reg_written <= wr && cur.rd != 5'd0;
          out_dest_reg    <= (wr && cur.rd != 5'd0) ? cur.rd : 5'd0;
          out_write_value <= (wr && cur.rd != 5'd0) ? val : 32'd0;
          if (wr && cur.rd != 5'd0) rf_r[cur.rd] <= val;
        end
      end
      if (st_r == S_LOAD) begin
        out_next_pc     <= ld_npc_r;
        out_status      <= ST_OK;
        out_reg_written <= ld_r.rd != 5'd0;
        out_dest_reg    <= ld_r.rd;
        out_write_value <= (ld_r.rd != 5'd0) ? ld_word : 32'd0;
        if (ld_r.rd != 5'd0) rf_r[ld_r.rd] <= ld_word;
      end
    end
  end
endmodule

// ----- design/rv32i_subset_execute.sv -----
// Top level: RV32I subset execute block
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall/in_instruction carries one instruction
//   word per beat. Output channel out_valid/out_stall carries next PC,
//   register write report and status for each instruction, in order.
//   A two-entry decode queue separates the decoder from the executer, so
//   the input keeps accepting beats while a result waits on out_stall.
//   A result passes the queue and then the result register. Throughput:
//   one instruction per cycle while out_stall is low; none is taken
//   while a load waits for its registered data memory read. After reset
//   the executer clears the data memory, one 32-bit row per cycle, until
//   DATA_BYTES bytes are zero; the decode queue fills meanwhile and then
//   stalls the input. The PC and the registers reset to zero. When the
//   receiver stalls, the result is held and the queue backs up.
module rv32i_subset_execute #(
  parameter int DATA_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_instruction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_next_pc,
  output logic               out_reg_written,
  output logic [4:0]         out_dest_reg,
  output logic signed [31:0] out_write_value,
  output logic [1:0]         out_status
);
  import rv32_pkg::*;

  logic q_valid, q_take;
  dec_t q_data;

  rv32_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_instruction,
    .q_valid, .q_data, .q_take
  );

  rv32_back #(.DATA_BYTES(DATA_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_take,
    .out_valid, .out_stall, .out_next_pc, .out_reg_written,
    .out_dest_reg, .out_write_value, .out_status
  );
endmodule
